// ===== hw/rtl/mhg_pkg.sv =====
// shared types, constants and the cordic angle table for the compass heading block
`default_nettype none

package mhg_pkg;

  localparam int SAMPLE_BITS   = 12;
  localparam int CORDIC_STAGES = 16;
  localparam int MAX_STAGES    = 24;

  localparam int CFG_W = 16;
  localparam int IDX_W = 3;

  // scaled axis: sample times unsigned gain, plus offset times 1024
  localparam int PROD_W = SAMPLE_BITS + CFG_W + 1;
  localparam int SUM_W  = PROD_W + 2;
  // negation and cordic gain need two more bits
  localparam int CW     = SUM_W + 2;

  // angle accumulator in 1/32768 degree
  localparam int AW        = 26;
  localparam int ANG_EXTRA = 8;
  localparam int RW        = AW - ANG_EXTRA;
  localparam int HW        = RW + 1;

  localparam int FULL_TURN = 46080;
  localparam int HALF_TURN = 23040;

  // register indexes
  localparam logic [IDX_W-1:0] REG_DECL = 3'd0;
  localparam logic [IDX_W-1:0] REG_GOAL = 3'd1;
  localparam logic [IDX_W-1:0] REG_XGN  = 3'd2;
  localparam logic [IDX_W-1:0] REG_YGN  = 3'd3;
  localparam logic [IDX_W-1:0] REG_XOFF = 3'd4;
  localparam logic [IDX_W-1:0] REG_YOFF = 3'd5;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] mag_x;
    logic signed [SAMPLE_BITS-1:0] mag_y;
  } mhg_in_t;

  typedef struct packed {
    logic        [15:0] heading;
    logic signed [15:0] goal_error;
  } mhg_out_t;

  typedef struct packed {
    logic signed [CFG_W-1:0] decl;
    logic        [CFG_W-1:0] goal;
    logic        [CFG_W-1:0] x_gain;
    logic        [CFG_W-1:0] y_gain;
    logic signed [CFG_W-1:0] x_off;
    logic signed [CFG_W-1:0] y_off;
  } mhg_cfg_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [AW-1:0] ang;
    logic                 zero;
  } mhg_vec_t;

  localparam mhg_cfg_t CFG_RESET = '{
    decl:   16'sd0,
    goal:   16'd0,
    x_gain: 16'd18789,
    y_gain: 16'd18589,
    x_off:  16'sd92,
    y_off:  16'sd536
  };

  // atan(2^-i) in 1/32768 degree, rounded to nearest
  function automatic logic signed [AW-1:0] atan_step(input int i);
    logic signed [AW-1:0] v;
    case (i)
      0:       v = AW'(1474560);
      1:       v = AW'(870484);
      2:       v = AW'(459940);
      3:       v = AW'(233473);
      4:       v = AW'(117189);
      5:       v = AW'(58652);
      6:       v = AW'(29333);
      7:       v = AW'(14667);
      8:       v = AW'(7334);
      9:       v = AW'(3667);
      10:      v = AW'(1833);
      11:      v = AW'(917);
      12:      v = AW'(458);
      13:      v = AW'(229);
      14:      v = AW'(115);
      15:      v = AW'(57);
      16:      v = AW'(29);
      17:      v = AW'(14);
      18:      v = AW'(7);
      19:      v = AW'(4);
      20:      v = AW'(2);
      21:      v = AW'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/mhg_scale.sv =====
// axis scaling, offset and half-plane pre-rotation, three register stages
`default_nettype none

module mhg_scale (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mhg_pkg::mhg_cfg_t cfg_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  mhg_pkg::mhg_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output mhg_pkg::mhg_vec_t out_data_o
);
  import mhg_pkg::*;

  logic [2:0] valid_q;
  logic [2:0] en;

  logic signed [PROD_W-1:0] prod_x_d, prod_y_d, prod_x_q, prod_y_q;
  logic signed [SUM_W-1:0]  sum_x_d, sum_y_d, sum_x_q, sum_y_q;
  logic signed [CW-1:0]     ext_x, ext_y;
  mhg_vec_t                 vec_d, vec_q;

  // a stage moves when it is empty or the next one moves
  assign en[2]      = !valid_q[2] || out_ready_i;
  assign en[1]      = !valid_q[1] || en[2];
  assign en[0]      = !valid_q[0] || en[1];
  assign in_ready_o = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en[0]) valid_q[0] <= in_valid_i;
      if (en[1]) valid_q[1] <= valid_q[0];
      if (en[2]) valid_q[2] <= valid_q[1];
    end
  end

  // stage 1: gain multiply
  assign prod_x_d = PROD_W'(in_data_i.mag_x) * PROD_W'($signed({1'b0, cfg_i.x_gain}));
  assign prod_y_d = PROD_W'(in_data_i.mag_y) * PROD_W'($signed({1'b0, cfg_i.y_gain}));

  // stage 2: offset in q.4 counts aligned to q.14
  assign sum_x_d = SUM_W'(prod_x_q) + (SUM_W'(cfg_i.x_off) <<< 10);
  assign sum_y_d = SUM_W'(prod_y_q) + (SUM_W'(cfg_i.y_off) <<< 10);

  // stage 3: fold left half plane onto the right one
  assign ext_x = CW'(sum_x_q);
  assign ext_y = CW'(sum_y_q);

  always_comb begin
    vec_d.zero = (sum_x_q == '0) && (sum_y_q == '0);
    if (sum_x_q < 0) begin
      vec_d.x   = -ext_x;
      vec_d.y   = -ext_y;
      vec_d.ang = (sum_y_q >= 0) ? AW'(HALF_TURN * 256) : AW'(-HALF_TURN * 256);
    end else begin
      vec_d.x   = ext_x;
      vec_d.y   = ext_y;
      vec_d.ang = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0] && in_valid_i) begin
      prod_x_q <= prod_x_d;
      prod_y_q <= prod_y_d;
    end
    if (en[1] && valid_q[0]) begin
      sum_x_q <= sum_x_d;
      sum_y_q <= sum_y_d;
    end
    if (en[2] && valid_q[1]) begin
      vec_q <= vec_d;
    end
  end

  assign out_valid_o = valid_q[2];
  assign out_data_o  = vec_q;

endmodule

`default_nettype wire

// ===== hw/rtl/mhg_cordic.sv =====
// vectoring cordic, one micro-rotation per register stage
`default_nettype none

module mhg_cordic #(
  parameter int STAGES = mhg_pkg::CORDIC_STAGES
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  mhg_pkg::mhg_vec_t in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output mhg_pkg::mhg_vec_t out_data_o
);
  import mhg_pkg::*;

  logic     valid_q [STAGES];
  mhg_vec_t vec_q   [STAGES];
  logic     stg_valid [STAGES+1];
  mhg_vec_t stg_vec   [STAGES+1];
  logic     rdy       [STAGES+1];

  assign stg_valid[0] = in_valid_i;
  assign stg_vec[0]   = in_data_i;
  assign rdy[STAGES]  = out_ready_i;

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    localparam logic signed [AW-1:0] ATAN_I = atan_step(i);
    mhg_vec_t vec_d;

    always_comb begin
      vec_d.zero = stg_vec[i].zero;
      if (stg_vec[i].y > 0) begin
        vec_d.x   = stg_vec[i].x + (stg_vec[i].y >>> i);
        vec_d.y   = stg_vec[i].y - (stg_vec[i].x >>> i);
        vec_d.ang = stg_vec[i].ang + ATAN_I;
      end else begin
        vec_d.x   = stg_vec[i].x - (stg_vec[i].y >>> i);
        vec_d.y   = stg_vec[i].y + (stg_vec[i].x >>> i);
        vec_d.ang = stg_vec[i].ang - ATAN_I;
      end
    end

    assign rdy[i] = !valid_q[i] || rdy[i+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[i] <= 1'b0;
      end else if (rdy[i]) begin
        valid_q[i] <= stg_valid[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[i] && stg_valid[i]) begin
        vec_q[i] <= vec_d;
      end
    end

    assign stg_valid[i+1] = valid_q[i];
    assign stg_vec[i+1]   = vec_q[i];
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = stg_valid[STAGES];
  assign out_data_o  = stg_vec[STAGES];

endmodule

`default_nettype wire

// ===== hw/rtl/mhg_wrap.sv =====
// angle rounding, declination, heading wrap and goal difference, five stages
`default_nettype none

module mhg_wrap (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mhg_pkg::mhg_cfg_t cfg_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  mhg_pkg::mhg_vec_t in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output mhg_pkg::mhg_out_t out_data_o
);
  import mhg_pkg::*;

  function automatic logic signed [HW-1:0] wrap_turn(input logic signed [HW-1:0] h);
    logic signed [HW-1:0] r;
    if (h < 0) begin
      r = h + HW'(FULL_TURN);
    end else if (h >= HW'(FULL_TURN)) begin
      r = h - HW'(FULL_TURN);
    end else begin
      r = h;
    end
    return r;
  endfunction

  logic [4:0] valid_q;
  logic [4:0] en;

  logic signed [AW-1:0] ang_sum;
  logic signed [RW-1:0] ang_rnd;
  logic signed [HW-1:0] h1_d, h1_q, h2_q, h3_q, d4_d, d4_q, d5;
  logic        [15:0]   h4_q;
  mhg_out_t             out_d, out_q;

  assign en[4]      = !valid_q[4] || out_ready_i;
  assign en[3]      = !valid_q[3] || en[4];
  assign en[2]      = !valid_q[2] || en[3];
  assign en[1]      = !valid_q[1] || en[2];
  assign en[0]      = !valid_q[0] || en[1];
  assign in_ready_o = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en[0]) valid_q[0] <= in_valid_i;
      if (en[1]) valid_q[1] <= valid_q[0];
      if (en[2]) valid_q[2] <= valid_q[1];
      if (en[3]) valid_q[3] <= valid_q[2];
      if (en[4]) valid_q[4] <= valid_q[3];
    end
  end

  // round to 1/128 degree, zero pair gives angle 0, then add declination
  assign ang_sum = in_data_i.ang + AW'(128);
  assign ang_rnd = in_data_i.zero ? '0 : $signed(ang_sum[AW-1:ANG_EXTRA]);
  assign h1_d    = HW'(ang_rnd) + HW'(cfg_i.decl);

  // goal difference, heading already in range
  assign d4_d = HW'($signed({1'b0, cfg_i.goal})) - h3_q;

  always_comb begin
    if (d4_q < -HW'(HALF_TURN)) begin
      d5 = d4_q + HW'(FULL_TURN);
    end else if (d4_q > HW'(HALF_TURN)) begin
      d5 = d4_q - HW'(FULL_TURN);
    end else begin
      d5 = d4_q;
    end
    out_d.heading    = h4_q;
    out_d.goal_error = d5[15:0];
  end

  always_ff @(posedge clk_i) begin
    if (en[0] && in_valid_i) h1_q <= h1_d;
    if (en[1] && valid_q[0]) h2_q <= wrap_turn(h1_q);
    if (en[2] && valid_q[1]) h3_q <= wrap_turn(h2_q);
    if (en[3] && valid_q[2]) begin
      h4_q <= h3_q[15:0];
      d4_q <= d4_d;
    end
    if (en[4] && valid_q[3]) out_q <= out_d;
  end

  assign out_valid_o = valid_q[4];
  assign out_data_o  = out_q;

  a_heading_wrapped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[2] |-> (h3_q >= 0) && (h3_q < HW'(FULL_TURN)))
    else $error("heading left [0,360) after two wrap steps");

  a_out_heading: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_q.heading < 16'(FULL_TURN)))
    else $error("heading output out of range");

  a_out_goal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_q.goal_error >= -16'sd23040) && (out_q.goal_error <= 16'sd23040))
    else $error("goal error out of range");

endmodule

`default_nettype wire

// ===== hw/rtl/magnetometer_heading_with_goal_offset_top.sv =====
// compass heading top level: config registers and the scale, cordic, wrap pipeline
// throughput: one transaction per cycle while out_stall_i is low, every stage is a
// register slice with valid bit
// stall: a stage holds while full and blocked, bubbles close up, nothing is lost
// reset: all valid bits cleared, config registers to declination 0, goal 0, default gains
// and offsets
`default_nettype none

module magnetometer_heading_with_goal_offset_top #(
  parameter int CORDIC_STAGES = mhg_pkg::CORDIC_STAGES
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // sample channel
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  mhg_pkg::mhg_in_t               in_data_i,
  // result channel
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output mhg_pkg::mhg_out_t              out_data_o,
  // config write port
  input  logic                           cfg_we_i,
  input  logic [mhg_pkg::IDX_W-1:0]      cfg_idx_i,
  input  logic [mhg_pkg::CFG_W-1:0]      cfg_data_i
);
  import mhg_pkg::*;

  mhg_cfg_t cfg_q;

  // handshake between the three sections
  logic     scl_ready, scl_valid, cor_ready, cor_valid, wrp_ready;
  mhg_vec_t scl_vec, cor_vec;

  // config registers, writes beyond the register list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_DECL: cfg_q.decl   <= cfg_data_i;
        REG_GOAL: cfg_q.goal   <= cfg_data_i;
        REG_XGN:  cfg_q.x_gain <= cfg_data_i;
        REG_YGN:  cfg_q.y_gain <= cfg_data_i;
        REG_XOFF: cfg_q.x_off  <= cfg_data_i;
        REG_YOFF: cfg_q.y_off  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // gain, offset and half-plane fold
  mhg_scale u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (scl_ready),
    .in_data_i   (in_data_i),
    .out_valid_o (scl_valid),
    .out_ready_i (cor_ready),
    .out_data_o  (scl_vec)
  );

  // atan2 by micro-rotations, one stage each
  mhg_cordic #(
    .STAGES (CORDIC_STAGES)
  ) u_cordic (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (scl_valid),
    .in_ready_o  (cor_ready),
    .in_data_i   (scl_vec),
    .out_valid_o (cor_valid),
    .out_ready_i (wrp_ready),
    .out_data_o  (cor_vec)
  );

  // rounding, declination, wraps; its last stage is the output register
  mhg_wrap u_wrap (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (cor_valid),
    .in_ready_o  (wrp_ready),
    .in_data_i   (cor_vec),
    .out_valid_o (out_valid_o),
    .out_ready_i (!out_stall_i),
    .out_data_o  (out_data_o)
  );

  assign in_stall_o = !scl_ready;

endmodule

`default_nettype wire
